/* src/slrg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator package
// Shared widths, constants, codes and the table access type.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int VALUE_W    = 31;
  localparam int ADDR_MAX_W = 8;

  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [ADDR_MAX_W-1:0] addr_t;

  localparam logic [14:0]  LEHMER_MUL = 15'd16807;
  localparam value_t       LEHMER_MOD = 31'h7FFF_FFFF;

  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_RESEED = 1'b1;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

endpackage
`default_nettype wire

/* src/slrg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator channels
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface slrg_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  slrg_pkg::value_t  range_limit;

  modport source (output valid, output mode, output range_limit, input ready);
  modport sink   (input valid, input mode, input range_limit, output ready);
endinterface

interface slrg_out_if;
  logic              valid;
  logic              ready;
  slrg_pkg::value_t  raw_value;
  slrg_pkg::value_t  scaled_value;

  modport source (output valid, output raw_value, output scaled_value, input ready);
  modport sink   (input valid, input raw_value, input scaled_value, output ready);
endinterface
`default_nettype wire

/* src/slrg_lehmer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Lehmer step unit
// Registers 16807 * x, then folds the product modulo 2^31 - 1.
// ----------------------------------------------------------------------------
module slrg_lehmer (
  input  logic             clk,
  input  slrg_pkg::value_t x,
  output slrg_pkg::value_t y
);

  logic [45:0] prod;
  logic [31:0] fold_sum;

  always_ff @(posedge clk) begin
    prod <= 46'(x) * 46'(slrg_pkg::LEHMER_MUL);
  end

  always_comb begin
    fold_sum = {1'b0, prod[30:0]} + 32'(prod[45:31]);
    if (fold_sum >= {1'b0, slrg_pkg::LEHMER_MOD}) begin
      y = 31'(fold_sum - {1'b0, slrg_pkg::LEHMER_MOD});
    end else begin
      y = fold_sum[30:0];
    end
  end

endmodule
`default_nettype wire

/* src/slrg_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffle table
// Synchronous memory with registered read data; unwritten entries read zero.
// ----------------------------------------------------------------------------
module slrg_table #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  slrg_pkg::mem_req_t req,
  output slrg_pkg::value_t   rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slrg_pkg::value_t mem [DEPTH];
  logic [DEPTH-1:0] written;
  slrg_pkg::value_t rd_q;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr[AW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        rd_written <= written[req.raddr[AW-1:0]];
      end
    end
  end

  assign rdata = rd_written ? rd_q : '0;

endmodule
`default_nettype wire

/* src/slrg_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Range scaler
// Registers limit * raw, then divides the product exactly by 2^31 - 1.
// ----------------------------------------------------------------------------
module slrg_scale (
  input  logic             clk,
  input  logic             load,
  input  slrg_pkg::value_t limit,
  input  slrg_pkg::value_t raw,
  output slrg_pkg::value_t scaled
);

  logic [61:0] prod;
  logic [31:0] part_sum;
  logic [31:0] quot;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 62'(limit) * 62'(raw);
    end
  end

  // With p = h * 2^31 + l, p / M = h + (h + l) / M, and h + l stays below 2M + 1.
  always_comb begin
    part_sum = {1'b0, prod[61:31]} + {1'b0, prod[30:0]};
    if (part_sum >= {slrg_pkg::LEHMER_MOD, 1'b0}) begin
      quot = {1'b0, prod[61:31]} + 32'd2;
    end else if (part_sum >= {1'b0, slrg_pkg::LEHMER_MOD}) begin
      quot = {1'b0, prod[61:31]} + 32'd1;
    end else begin
      quot = {1'b0, prod[61:31]};
    end
  end

  assign scaled = quot[30:0];

endmodule
`default_nettype wire

/* src/shuffled_lehmer_random_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Shuffled Lehmer random generator
// A draw gives a valid result after the steps multiply, fold with slot pick,
// table read, table write with scaling and result load; no new transaction is
// taken until the draw is done. A held result stalls the last step.
// A reseed alternates the multiply and fold steps until its warm-up count ends.
// Reset loads seed and generator with 1, clears last output to zero and makes every table entry read zero.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator #(
  parameter int TABLE_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  slrg_pkg::value_t cfg_write_data,
  slrg_in_if.sink          in_ch,
  slrg_out_if.source       out_ch
);

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int QW = $clog2(TABLE_SIZE) + 1;
  localparam int WW = $clog2(TABLE_SIZE + 8);
  localparam longint SLOT_DIV = 1 + (2147483646 / TABLE_SIZE);
  localparam int SLOT_SHIFT = slrg_pkg::VALUE_W + $clog2(SLOT_DIV);
  // The rounded-up reciprocal gives the exact quotient for every 31-bit value.
  localparam logic [31:0] SLOT_RECIP =
    32'(((longint'(1) << SLOT_SHIFT) + SLOT_DIV - 1) / SLOT_DIV);
  localparam logic [WW-1:0] WARM_INIT = WW'(TABLE_SIZE + 7);
  localparam logic [QW-1:0] SLOT_MAX  = QW'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FOLD,
    S_READ,
    S_UPDATE,
    S_SCALE
  } state_t;

  state_t             state;
  logic               reseeding;
  slrg_pkg::value_t   seed;
  slrg_pkg::value_t   lehmer;
  slrg_pkg::value_t   last_output;
  slrg_pkg::value_t   range_reg;
  logic [WW-1:0]      warm_cnt;
  logic [QW-1:0]      quot;
  logic               out_valid;
  slrg_pkg::value_t   out_raw;
  slrg_pkg::value_t   out_scaled;

  slrg_pkg::value_t   adv_y;
  slrg_pkg::value_t   tbl_rdata;
  slrg_pkg::value_t   scaled;
  slrg_pkg::mem_req_t tbl_req;
  logic [QW-1:0]      slot_sat;
  logic [62:0]        slot_prod;

  slrg_lehmer u_lehmer (
    .clk (clk),
    .x   (lehmer),
    .y   (adv_y)
  );

  slrg_table #(
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  slrg_scale u_scale (
    .clk    (clk),
    .load   (state == S_UPDATE),
    .limit  (range_reg),
    .raw    (tbl_rdata),
    .scaled (scaled)
  );

  assign slot_sat  = (quot >= QW'(TABLE_SIZE)) ? SLOT_MAX : quot;
  assign slot_prod = 63'(last_output) * 63'(SLOT_RECIP);

  always_comb begin
    tbl_req = '0;
    case (state)
      S_FOLD: begin
        if (reseeding && (warm_cnt < WW'(TABLE_SIZE))) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = slrg_pkg::addr_t'(warm_cnt[AW-1:0]);
          tbl_req.wdata = adv_y;
        end
      end
      S_READ: begin
        tbl_req.re    = 1'b1;
        tbl_req.raddr = slrg_pkg::addr_t'(slot_sat[AW-1:0]);
      end
      S_UPDATE: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = slrg_pkg::addr_t'(slot_sat[AW-1:0]);
        tbl_req.wdata = lehmer;
      end
      default: begin
        tbl_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      reseeding   <= 1'b0;
      seed        <= 31'd1;
      lehmer      <= 31'd1;
      last_output <= '0;
      warm_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        seed <= cfg_write_data;
      end
      if (out_valid && out_ch.ready && (state != S_SCALE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            range_reg <= in_ch.range_limit;
            if (in_ch.mode == slrg_pkg::MODE_RESEED) begin
              reseeding <= 1'b1;
              lehmer    <= seed;
              warm_cnt  <= WARM_INIT;
            end else begin
              reseeding <= 1'b0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          lehmer <= adv_y;
          if (reseeding) begin
            if (warm_cnt == '0) begin
              last_output <= adv_y;
              state       <= S_IDLE;
            end else begin
              warm_cnt <= warm_cnt - 1'b1;
              state    <= S_MUL;
            end
          end else begin
            quot  <= QW'(slot_prod >> SLOT_SHIFT);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          last_output <= tbl_rdata;
          state       <= S_SCALE;
        end
        S_SCALE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_raw    <= last_output;
            out_scaled <= scaled;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.raw_value    = out_raw;
  assign out_ch.scaled_value = out_scaled;

`ifndef SYNTH
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (slot_sat < QW'(TABLE_SIZE)))
    else $error("Table slot out of range.");

  a_lehmer_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |=> (lehmer != slrg_pkg::LEHMER_MOD))
    else $error("Generator state not reduced modulo 2^31 - 1.");

  a_result_from_scale: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SCALE))
    else $error("Result loaded outside the scale step.");
`endif

endmodule
`default_nettype wire
